### sv/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIX  = 3'b100
  } sid_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture operands, magnitudes and special cases
    logic step;    // one restoring shift-subtract iteration
    logic finish;  // apply sign and write the output register
  } sid_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;  // zero divisor or saturating overflow, no iterations needed
  } sid_status_t;

endpackage

### sv/sid_datapath.sv
`timescale 1ns / 1ps

module sid_datapath import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  sid_cmd_t                     cmd,
  output sid_status_t                  status,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         overflow,
  output logic                         divide_by_zero
);

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

  // Working registers: na_r shifts the dividend out and the quotient in
  logic [DATA_WIDTH-1:0] na_r, na_nxt;
  logic [DATA_WIDTH-1:0] nb_r, nb_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic                  dbz_r, dbz_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic                  q_ovf_r, q_ovf_nxt;
  logic                  q_dbz_r, q_dbz_nxt;

  logic [DATA_WIDTH-1:0] a_u, b_u;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  assign a_u = dividend;
  assign b_u = divisor;

  // Partial remainder shifted by one with the next dividend bit
  assign rem_sh = {rem_r, na_r[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, nb_r};

  // Load, iterate and finish
  always_comb begin
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    dbz_nxt   = dbz_r;
    ovf_nxt   = ovf_r;
    q_nxt     = q_r;
    q_ovf_nxt = q_ovf_r;
    q_dbz_nxt = q_dbz_r;
    if (cmd.load) begin
      na_nxt  = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
      nb_nxt  = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
      rem_nxt = '0;
      neg_nxt = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      dbz_nxt = (b_u == '0);
      ovf_nxt = (a_u == MOST_NEG) && (b_u == ALL_ONES);
    end else if (cmd.step) begin
      // Restoring step: subtract when the remainder covers the divisor
      if (!diff[DATA_WIDTH]) begin
        rem_nxt = diff[DATA_WIDTH-1:0];
      end else begin
        rem_nxt = rem_sh[DATA_WIDTH-1:0];
      end
      na_nxt = {na_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
    end
    if (cmd.finish) begin
      q_ovf_nxt = ovf_r;
      q_dbz_nxt = dbz_r;
      if (dbz_r) begin
        q_nxt = '0;
      end else if (ovf_r) begin
        q_nxt = MOST_POS;
      end else if (neg_r) begin
        q_nxt = ~na_r + 1'b1;
      end else begin
        q_nxt = na_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= na_nxt;
    nb_r    <= nb_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    dbz_r   <= dbz_nxt;
    ovf_r   <= ovf_nxt;
    q_r     <= q_nxt;
    q_ovf_r <= q_ovf_nxt;
    q_dbz_r <= q_dbz_nxt;
  end

  assign status.special = dbz_r | ovf_r;
  assign quotient       = q_r;
  assign overflow       = q_ovf_r;
  assign divide_by_zero = q_dbz_r;

endmodule

### sv/sid_ctrl.sv
`timescale 1ns / 1ps

module sid_ctrl import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output sid_cmd_t    cmd,
  input  sid_status_t status
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  sid_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Sequence: accept, iterate once per quotient bit (skipped for special cases), fix sign into output
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (status.special) begin
          state_nxt = ST_FIX;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_nxt = ST_FIX;
          end
        end
      end
      ST_FIX: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while holding a beat");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  a_load_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_CALC) && (cnt_r == '0))
    else $error("load did not start iteration");

  a_calc_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) && !status.special && (cnt_r != CNT_LAST) |=> (state_r == ST_CALC))
    else $error("iteration ended early");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

### sv/signed_integer_divider.sv
`timescale 1ns / 1ps

// Signed integer divider, quotient truncated toward zero.
// Input channel in_*: one beat carries dividend and divisor; it is taken
// while the block is idle (in_tready high), one item at a time.
// Output channel out_*: one beat per input beat, quotient in out_tdata,
// overflow and divide-by-zero flags in out_tuser.
// Processing: one restoring shift-subtract step per quotient bit, then a
// sign-fix step that applies the sign into the output register. A zero
// divisor or most-negative over minus one skips the iterations. The single
// shift-subtract unit takes one item at a time; the beat is taken in the
// idle state, and a new item is accepted while the previous result still
// waits in the output register.
// Receiver stall: the result holds in the output register; a finished
// division waits in its sign-fix step until the register frees.
// Reset (rst_n low, synchronous): control returns to idle, any item in
// flight and any pending result are dropped.
module signed_integer_divider import sid_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [DATA_WIDTH-1:0] dividend, [2*DATA_WIDTH-1:DATA_WIDTH] divisor, zero pad above
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [DATA_WIDTH-1:0] quotient, zero pad above
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      out_tdata,
  // [0] overflow, [1] divide_by_zero
  output logic [1:0]                           out_tuser
);

  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  sid_cmd_t                     cmd;
  sid_status_t                  status;
  logic signed [DATA_WIDTH-1:0] dividend;
  logic signed [DATA_WIDTH-1:0] divisor;
  logic signed [DATA_WIDTH-1:0] quotient;
  logic                         overflow;
  logic                         divide_by_zero;

  // Unpack input beat
  assign dividend = in_tdata[DATA_WIDTH-1:0];
  assign divisor  = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  sid_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  sid_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .dividend       (dividend),
    .divisor        (divisor),
    .quotient       (quotient),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  // Pack output beat
  assign out_tdata = OUT_TDATA_W'($unsigned(quotient));
  assign out_tuser = {divide_by_zero, overflow};

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sid_pkg::*;

  localparam int W = 32;
  localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = '1;
  localparam logic [W-1:0] ZERO      = '0;
  localparam logic [W-1:0] ONE       = 1;

  // Flag positions in out_tuser
  localparam int FLAG_OVERFLOW = 0;
  localparam int FLAG_DIV_ZERO = 1;

  // Receiver behavior modes
  localparam int RX_FLOW   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_STALL  = 2;

  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = 3 * (W + 2);

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         overflow;
    logic         divide_by_zero;
  } quot_t;

  // Expected quotients in arrival order, compared against each result beat
  class quotient_scoreboard;
    quot_t expected_q[$];
    int    failures;

    function new();
      failures = 0;
    endfunction

    // Restoring shift-subtract on magnitudes, sign from the operand signs
    function quot_t divide(logic [W-1:0] dividend, logic [W-1:0] divisor);
      quot_t        res;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] quo;
      logic [W:0]   rem;
      res = '0;
      if (divisor == ZERO) begin
        res.divide_by_zero = 1'b1;
        return res;
      end
      if (dividend == MOST_NEG && divisor == MINUS_ONE) begin
        res.quotient = MOST_POS;
        res.overflow = 1'b1;
        return res;
      end
      mag_a = dividend[W-1] ? -dividend : dividend;
      mag_b = divisor[W-1] ? -divisor : divisor;
      quo = '0;
      rem = '0;
      for (int i = W - 1; i >= 0; i--) begin
        rem = {rem[W-1:0], mag_a[i]};
        quo = {quo[W-2:0], 1'b0};
        if (rem >= {1'b0, mag_b}) begin
          rem = rem - {1'b0, mag_b};
          quo[0] = 1'b1;
        end
      end
      res.quotient = (dividend[W-1] ^ divisor[W-1]) ? -quo : quo;
      return res;
    endfunction

    function void note_division(logic [W-1:0] dividend, logic [W-1:0] divisor);
      expected_q.push_back(divide(dividend, divisor));
    endfunction

    function void check_result(logic [W-1:0] quotient, logic [1:0] flags);
      quot_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result beat with nothing pending: quotient %h flags %b",
                   $time, quotient, flags);
        return;
      end
      want = expected_q.pop_front();
      if (quotient !== want.quotient || flags[FLAG_OVERFLOW] !== want.overflow ||
          flags[FLAG_DIV_ZERO] !== want.divide_by_zero) begin
        failures++;
        if (failures <= 10)
          $display("%0t: quotient exp %h got %h, overflow exp %b got %b, div0 exp %b got %b",
                   $time, want.quotient, quotient, want.overflow, flags[FLAG_OVERFLOW],
                   want.divide_by_zero, flags[FLAG_DIV_ZERO]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // [31:0] dividend, [63:32] divisor
  logic [2*W-1:0]   in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [31:0] quotient
  logic [W-1:0]     out_tdata;
  // [0] overflow, [1] divide_by_zero
  logic [1:0]       out_tuser;

  quotient_scoreboard sb;
  int rx_mode = RX_FLOW;
  int rx_left = 0;

  signed_integer_divider #(.DATA_WIDTH(W)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: alternate between free flow, random ready and solid stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_FLOW, RX_STALL);
      rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 40) : $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= $urandom_range(0, 1);
      default:   out_tready <= 1'b0;
    endcase
  end

  // Track accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_division(in_tdata[W-1:0], in_tdata[2*W-1:W]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  // Present one beat and hold it until accepted
  task automatic send_division(input logic [W-1:0] dividend, input logic [W-1:0] divisor);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid for a number of cycles
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold off until every pending quotient has come back
  task automatic drain_results();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Operand shapes: full range, small values, extremes, powers of two, scaled
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = $urandom;
      4: val = $urandom_range(0, 64);
      5: begin
        case ($urandom_range(0, 4))
          0: val = MOST_NEG;
          1: val = MOST_POS;
          2: val = ZERO;
          3: val = MINUS_ONE;
          default: val = ONE;
        endcase
      end
      6: val = ONE << $urandom_range(0, W - 1);
      default: val = $urandom >> $urandom_range(0, W - 1);
    endcase
    if ($urandom_range(0, 1))
      val = -val;
    return val;
  endfunction

  initial begin
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    int           burst_left;
    sb = new();
    burst_left = 0;

    // Hold reset low before releasing it
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, signs, zero divisor, saturating overflow
    send_division(ZERO, ONE);
    send_division(ONE, ONE);
    send_division(MINUS_ONE, ONE);
    send_division(MOST_POS, ONE);
    send_division(MOST_NEG, ONE);
    send_division(MOST_NEG, MINUS_ONE);
    send_division(MOST_POS, MINUS_ONE);
    send_division(ZERO, ZERO);
    send_division(MOST_NEG, ZERO);
    send_division(MOST_POS, ZERO);
    send_division(32'd123456789, ZERO);
    send_division(MOST_NEG, MOST_NEG);
    send_division(MOST_POS, MOST_POS);
    send_division(MOST_POS, MOST_NEG);
    send_division(MOST_NEG, MOST_POS);
    send_division(32'd7, -32'd2);
    send_division(-32'd7, 32'd2);
    send_division(-32'd7, -32'd2);
    send_division(32'd5, 32'd7);
    send_division(ZERO, MINUS_ONE);
    send_division(MOST_NEG, 32'd2);
    send_division(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_division(32'h5555_5555, 32'hAAAA_AAAA);

    // Random: bursts of beats separated by random gaps
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2)
        drain_results();
      if (burst_left == 0) begin
        pause_sender($urandom_range(0, 16));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      if ($urandom_range(0, 49) == 0) begin
        dividend = MOST_NEG;
        divisor  = MINUS_ONE;
      end else begin
        dividend = pick_operand();
        divisor  = pick_operand();
      end
      send_division(dividend, divisor);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
sv/sid_pkg.sv
sv/sid_datapath.sv
sv/sid_ctrl.sv
sv/signed_integer_divider.sv
test/testbench.sv
